/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the matrix multiply engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mme_pkg.sv */
// Shared constants, request codes and pipeline tag type of the matrix multiply engine.
`timescale 1ns / 1ps

package mme_pkg;

    // Default sizing
    localparam int MAX_DIM_DEF   = 8;
    localparam int DATA_W_DEF    = 16;
    localparam int FRAC_BITS_DEF = 12;

    // Fixed field widths
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 3;
    localparam int REQ_W     = 2;
    localparam int ACC_W     = 64;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

    // Control tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first;       // first inner step of an element
        logic             last;        // last inner step of an element
        logic             final_elem;  // element is the last one of the result
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } mme_tag_t;

endpackage

/* hdl/mme_store.sv */
// Single-port-write, single-port-read synchronous element store.
`timescale 1ns / 1ps

module mme_store #(
    parameter int DEPTH  = mme_pkg::MAX_DIM_DEF * mme_pkg::MAX_DIM_DEF,
    parameter int DATA_W = mme_pkg::DATA_W_DEF
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic signed [DATA_W-1:0]    wdata,
    input  logic                        re,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output logic signed [DATA_W-1:0]    rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while the pipeline is frozen
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/mme_mac.sv */
// Multiply-accumulate unit with 64-bit saturating accumulator and output scaling.
`timescale 1ns / 1ps

module mme_mac #(
    parameter int DATA_W    = mme_pkg::DATA_W_DEF,
    parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  mme_pkg::mme_tag_t         tag_in,
    input  logic signed [DATA_W-1:0]  a_data,
    input  logic signed [DATA_W-1:0]  b_data,
    output mme_pkg::mme_tag_t         tag_out,
    output logic signed [DATA_W-1:0]  value,
    output logic                      saturated
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = mme_pkg::ACC_W;

    mme_pkg::mme_tag_t        tag2_reg;
    mme_pkg::mme_tag_t        tag3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-DATA_W:0]    upper;
    logic                     in_range;

    assign prod_next = PROD_W'(a_data) * PROD_W'(b_data);

    // Saturating add at the accumulator limits; restart on the first step
    always_comb
    begin
        acc_base = tag2_reg.first ? '0 : acc_reg;
        acc_sum  = {acc_base[ACC_W-1], acc_base}
                 + {{(ACC_W + 1 - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (adv)
        begin
            tag2_reg <= tag_in;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            if (tag2_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // Drop the fraction (floor) and clip to the element width
    assign shifted  = acc_reg >>> FRAC_BITS;
    assign upper    = shifted[ACC_W-1:DATA_W-1];
    assign in_range = (&upper) || (~|upper);

    always_comb
    begin
        if (in_range)
        begin
            value = shifted[DATA_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            value = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign saturated = !in_range;
    assign tag_out   = tag3_reg;

endmodule

/* hdl/matrix_multiply_engine_core.sv */
`timescale 1ns / 1ps
// Top level of the matrix multiply engine: sequencer, element stores, MAC and output register.
// Computes C = A x B on signed fixed point (Q4.12 by default). A write request stores one
// element of A or B; a write outside the stores is dropped. A compute request walks C in
// row-major order and issues one multiply-accumulate per cycle through a single MAC while
// the pipeline is not frozen by a stalled output, so it keeps the input stalled until its
// last multiply-accumulate is issued; results pass through the store read, product,
// accumulate and output registers. Each element is floor-shifted by the fraction bits and
// clipped to the element width, with saturated set when clipped, and last marks the final
// element. Dimension registers clamp 0 to 1 and large values to the maximum.
// The stores have no reset: read only elements that were written. Write the dimension
// registers only while no request is in flight.

`include "assert_macros.svh"

module matrix_multiply_engine_core #(
    parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
    parameter int DATA_W    = mme_pkg::DATA_W_DEF,
    parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]          cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mme_pkg::REQ_W-1:0]          req_type,
    input  logic [mme_pkg::POS_W-1:0]          row_index,
    input  logic [mme_pkg::POS_W-1:0]          col_index,
    input  logic signed [DATA_W-1:0]           elem_value,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mme_pkg::POS_W-1:0]          out_row,
    output logic [mme_pkg::POS_W-1:0]          out_col,
    output logic signed [DATA_W-1:0]           out_value,
    output logic                               saturated,
    output logic                               last
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = mme_pkg::POS_W;
    localparam int CFG_W  = mme_pkg::CFG_W;

    // Clamp a dimension to 1..MAX_DIM and return its last index
    function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] c;
        if (v == '0)
        begin
            c = CFG_W'(1);
        end
        else if (v > CFG_W'(MAX_DIM))
        begin
            c = CFG_W'(MAX_DIM);
        end
        else
        begin
            c = v;
        end
        return IDX_W'(c - CFG_W'(1));
    endfunction

    // Dimension registers, kept as last index
    logic [IDX_W-1:0] rows_last_reg;
    logic [IDX_W-1:0] inner_last_reg;
    logic [IDX_W-1:0] cols_last_reg;

    // Sequencer
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic accept;
    logic is_compute;
    logic wr_ok;
    logic we_a;
    logic we_b;
    logic issue;
    logic adv;
    logic done;

    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;

    logic signed [DATA_W-1:0] rd_a;
    logic signed [DATA_W-1:0] rd_b;

    mme_pkg::mme_tag_t        tag1_reg;
    mme_pkg::mme_tag_t        mac_tag;
    logic signed [DATA_W-1:0] mac_value;
    logic                     mac_sat;

    // Output register
    logic                     out_valid_reg;
    logic [POS_W-1:0]         out_row_reg;
    logic [POS_W-1:0]         out_col_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     saturated_reg;
    logic                     last_reg;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_last_reg  <= IDX_W'(MAX_DIM - 1);
            inner_last_reg <= IDX_W'(MAX_DIM - 1);
            cols_last_reg  <= IDX_W'(MAX_DIM - 1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mme_pkg::CFG_ROWS_A:     rows_last_reg  <= dim_last(cfg_data);
                mme_pkg::CFG_INNER_SIZE: inner_last_reg <= dim_last(cfg_data);
                mme_pkg::CFG_COLS_B:     cols_last_reg  <= dim_last(cfg_data);
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request intake: hold the request channel while a product is issuing
    // ------------------------------------------------------------------
    assign in_stall   = busy_reg;
    assign accept     = in_valid && !in_stall;
    assign is_compute = accept && (req_type == mme_pkg::REQ_COMPUTE);

    // Drop writes whose position falls outside the stores
    assign wr_ok = accept
                && ({1'b0, row_index} < (POS_W + 1)'(MAX_DIM))
                && ({1'b0, col_index} < (POS_W + 1)'(MAX_DIM));
    assign we_a  = wr_ok && (req_type == mme_pkg::REQ_WRITE_A);
    assign we_b  = wr_ok && (req_type == mme_pkg::REQ_WRITE_B);
    assign waddr = ADDR_W'(row_index[IDX_W-1:0]) * ADDR_W'(MAX_DIM)
                 + ADDR_W'(col_index[IDX_W-1:0]);

    // ------------------------------------------------------------------
    // Pipeline advance: freeze the sequencer, store reads and MAC while a finished element
    // waits on a stalled, full output register
    // ------------------------------------------------------------------
    assign done  = mac_tag.valid && mac_tag.last;
    assign adv   = !(done && out_valid_reg && out_stall);
    assign issue = busy_reg && adv;

    // ------------------------------------------------------------------
    // Sequencer: k innermost, then column, then row
    // ------------------------------------------------------------------
    always_comb
    begin
        busy_next = busy_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        if (is_compute)
        begin
            busy_next = 1'b1;
            i_next    = '0;
            j_next    = '0;
            k_next    = '0;
        end
        else if (issue)
        begin
            if (k_reg == inner_last_reg)
            begin
                k_next = '0;
                if (j_reg == cols_last_reg)
                begin
                    j_next = '0;
                    if (i_reg == rows_last_reg)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            else
            begin
                k_next = k_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            k_reg    <= k_next;
        end
    end

    // A(i,k) and B(k,j) addresses
    assign raddr_a = ADDR_W'(i_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
    assign raddr_b = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);

    // Tag aligned with the registered store read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg.valid      <= busy_reg;
            tag1_reg.first      <= (k_reg == '0);
            tag1_reg.last       <= (k_reg == inner_last_reg);
            tag1_reg.final_elem <= (i_reg == rows_last_reg) && (j_reg == cols_last_reg);
            tag1_reg.row        <= POS_W'(i_reg);
            tag1_reg.col        <= POS_W'(j_reg);
        end
    end

    // ------------------------------------------------------------------
    // Element stores
    // ------------------------------------------------------------------
    mme_store #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (elem_value),
        .re    (adv),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    mme_store #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (elem_value),
        .re    (adv),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    // ------------------------------------------------------------------
    // Multiply-accumulate
    // ------------------------------------------------------------------
    mme_mac #(
        .DATA_W    (DATA_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .tag_in    (tag1_reg),
        .a_data    (rd_a),
        .b_data    (rd_b),
        .tag_out   (mac_tag),
        .value     (mac_value),
        .saturated (mac_sat)
    );

    // ------------------------------------------------------------------
    // Output register: load a finished element, drop the held one once taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done && adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && adv)
        begin
            out_row_reg   <= mac_tag.row;
            out_col_reg   <= mac_tag.col;
            out_value_reg <= mac_value;
            saturated_reg <= mac_sat;
            last_reg      <= mac_tag.final_elem;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign saturated = saturated_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_done_held, done && out_valid_reg && out_stall, done, "finished element lost while output stalled")
    `ASSERT_NEXT(a_done_loaded, done && adv, out_valid_reg, "finished element not loaded into output register")
    `ASSERT_NEXT(a_seq_frozen, busy_reg && !adv, $stable(i_reg) && $stable(j_reg) && $stable(k_reg), "sequencer moved while pipeline frozen")
    `ASSERT_NEXT(a_compute_starts, is_compute, busy_reg, "compute request did not start the sequencer")

endmodule
